[hdl/mqf_pkg.sv]
`timescale 1ns / 1ps

package mqf_pkg;

    localparam int QNUM_BITS = 4;
    localparam int CFG_BITS  = 4;
    localparam int ITEM_W    = 32;
    localparam int STAT_BITS = 3;

    localparam logic REQ_ENTER = 1'b0;
    localparam logic REQ_LEAVE = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_ENTERED   = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_DEPARTED  = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_BAD_QUEUE = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd4;

    localparam logic [CFG_BITS-1:0] QUEUES_RESET = 4'd8;

    typedef struct packed {
        logic                 req_type;
        logic [QNUM_BITS-1:0] queue_number;
        logic [ITEM_W-1:0]    item_value;
    } req_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [ITEM_W-1:0]    departed_item;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
        logic emit_read;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic depart;
    } dp_stat_t;

endpackage

[hdl/mqf_ram.sv]
`timescale 1ns / 1ps

module mqf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mqf_ctrl.sv]
`timescale 1ns / 1ps

module mqf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mqf_pkg::dp_stat_t stat,
    output mqf_pkg::ctl_cmd_t cmd,
    output logic              busy
);

    mqf_pkg::ctl_state_t state_reg;
    mqf_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mqf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mqf_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = mqf_pkg::S_EXEC;
                end
            end
            mqf_pkg::S_EXEC:
            begin
                state_next = stat.depart ? mqf_pkg::S_READ : mqf_pkg::S_IDLE;
            end
            mqf_pkg::S_READ:
            begin
                state_next = mqf_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mqf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            mqf_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            mqf_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.emit = !stat.depart;
            end
            mqf_pkg::S_READ:
            begin
                cmd.emit_read = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[hdl/mqf_datapath.sv]
`timescale 1ns / 1ps

module mqf_datapath #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int ITEM_BITS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mqf_pkg::ctl_cmd_t                   cmd,
    output mqf_pkg::dp_stat_t                   stat,
    input  mqf_pkg::req_t                       req,
    input  logic                                cfg_we,
    input  logic [mqf_pkg::CFG_BITS-1:0]        cfg_wdata,
    output mqf_pkg::rsp_t                       rsp,
    output logic                                done
);

    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] DEPTH_A  = AW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] LAST_S   = SW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_C   = CW'(QUEUE_DEPTH);
    localparam logic [mqf_pkg::CFG_BITS-1:0] NQ_C = mqf_pkg::CFG_BITS'(NUM_QUEUES);

    mqf_pkg::req_t                  req_reg;
    mqf_pkg::rsp_t                  rsp_reg;
    logic                           done_reg;
    logic [mqf_pkg::CFG_BITS-1:0]   queues_reg;

    logic [SW-1:0] head_reg [NUM_QUEUES];
    logic [SW-1:0] tail_reg [NUM_QUEUES];
    logic [CW-1:0] fill_reg [NUM_QUEUES];

    logic [mqf_pkg::CFG_BITS-1:0]   count;
    logic                           bad;
    logic                           leave;
    logic [QW-1:0]                  q;
    logic [SW-1:0]                  head_cur;
    logic [SW-1:0]                  tail_cur;
    logic [CW-1:0]                  fill_cur;
    logic                           empty;
    logic                           full;
    logic [SW-1:0]                  head_next;
    logic [SW-1:0]                  tail_next;
    logic [mqf_pkg::STAT_BITS-1:0]  status_now;
    logic                           do_write;
    logic                           do_read;
    logic [AW-1:0]                  addr;
    logic [ITEM_BITS-1:0]           rd_data;

    always_comb
    begin
        count    = (queues_reg > NQ_C) ? NQ_C : queues_reg;
        bad      = (req_reg.queue_number == '0) || (req_reg.queue_number > count);
        leave    = (req_reg.req_type == mqf_pkg::REQ_LEAVE);
        q        = QW'(req_reg.queue_number - 4'd1);
        head_cur = '0;
        tail_cur = '0;
        fill_cur = '0;
        if (!bad)
        begin
            head_cur = head_reg[q];
            tail_cur = tail_reg[q];
            fill_cur = fill_reg[q];
        end
        empty     = (fill_cur == '0);
        full      = (fill_cur == FULL_C);
        head_next = (head_cur == LAST_S) ? '0 : head_cur + 1'b1;
        tail_next = (tail_cur == LAST_S) ? '0 : tail_cur + 1'b1;

        if (bad)
        begin
            status_now = mqf_pkg::ST_BAD_QUEUE;
        end
        else if (leave)
        begin
            status_now = empty ? mqf_pkg::ST_EMPTY : mqf_pkg::ST_DEPARTED;
        end
        else
        begin
            status_now = full ? mqf_pkg::ST_FULL : mqf_pkg::ST_ENTERED;
        end

        stat.depart = !bad && leave && !empty;
        do_write    = cmd.exec && !bad && !leave && !full;
        do_read     = cmd.exec && stat.depart;
        addr        = AW'(AW'(q) * DEPTH_A) + AW'(leave ? head_cur : tail_cur);
    end

    mqf_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_write),
        .re    (do_read),
        .addr  (addr),
        .wdata (ITEM_BITS'(req_reg.item_value)),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.emit)
        begin
            rsp_reg.status        <= status_now;
            rsp_reg.departed_item <= '0;
        end
        else if (cmd.emit_read)
        begin
            rsp_reg.status        <= mqf_pkg::ST_DEPARTED;
            rsp_reg.departed_item <= mqf_pkg::ITEM_W'(rd_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            queues_reg <= mqf_pkg::QUEUES_RESET;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.emit || cmd.emit_read;
            if (cfg_we)
            begin
                queues_reg <= cfg_wdata;
            end
            if (do_write)
            begin
                tail_reg[q] <= tail_next;
                fill_reg[q] <= fill_cur + 1'b1;
            end
            if (do_read)
            begin
                head_reg[q] <= head_next;
                fill_reg[q] <= fill_cur - 1'b1;
            end
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

[hdl/multi_queue_fifo_router_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// request   start & !busy         req  (req_type, queue_number, item_value)
// result    done, one cycle       rsp  (status, departed_item)
// config    cfg_we                cfg_wdata (queues_in_use)
//
// An item is taken in one cycle, checked and applied in the next.
// Results strobe from a register after the check; a departure first adds a state for the store read.
// busy stays high until the result is out; one item is in flight at a time.
// rst_n clears all queues to empty and sets queues_in_use to 8.
// The store contents are not cleared. The receiver cannot stall done.

module multi_queue_fifo_router_core #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int ITEM_BITS   = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mqf_pkg::req_t                req,
    output logic                         done,
    output mqf_pkg::rsp_t                rsp,
    input  logic                         cfg_we,
    input  logic [mqf_pkg::CFG_BITS-1:0] cfg_wdata
);

    mqf_pkg::ctl_cmd_t cmd;
    mqf_pkg::dp_stat_t stat;

    mqf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mqf_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_BITS   (ITEM_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp),
        .done      (done)
    );

endmodule
